@@ rtl/stscan_pkg.sv @@
// Shared constants, field layout and control types of the scrolling text row scanner.
// Used by stscan_place, the top level and the testbench; depends on nothing.
package stscan_pkg;

	// store sizes
	localparam int MAX_TEXT    = 64;
	localparam int FONT_CODES  = 128;
	localparam int TEXT_AW     = $clog2(MAX_TEXT);
	localparam int FONT_CODE_W = $clog2(FONT_CODES);
	localparam int ROW_W       = 3;
	localparam int FONT_AW     = FONT_CODE_W + ROW_W;
	localparam int FONT_DEPTH  = FONT_CODES * 8;

	// field widths
	localparam int MODE_W  = 2;
	localparam int POSN_W  = 7;
	localparam int CODE_W  = 7;
	localparam int GLYPH_W = 5;
	localparam int WORD_W  = 32;

	// scroll geometry
	localparam int GLYPH_PITCH   = 6;
	localparam int WRAP_EXTRA    = 35;
	localparam int FROZEN_OFFSET = 36;
	localparam int START_POS     = 6 * GLYPH_PITCH;
	localparam int OFF_W         = 9;
	localparam int TICK_W        = 8;
	localparam int LEN_W         = 7;
	localparam int LEN_CNT_W     = $clog2(MAX_TEXT + 1);
	localparam int POS_W         = $clog2((MAX_TEXT + 6) * GLYPH_PITCH);
	localparam int AMT_W         = ((POS_W > OFF_W) ? POS_W : OFF_W) + 1;
	localparam int BOUND_W       = $clog2(MAX_TEXT * GLYPH_PITCH + WRAP_EXTRA + 1);
	localparam int CMP_W         = (BOUND_W > OFF_W) ? BOUND_W : OFF_W;

	// input item layout in s_tdata
	localparam int S_POSN_LO  = 0;
	localparam int S_GROW_LO  = S_POSN_LO + POSN_W;
	localparam int S_VALUE_LO = S_GROW_LO + ROW_W;
	localparam int S_DATA_W   = 24;

	// result item layout in m_tdata
	localparam int M_ROW_LO  = 0;
	localparam int M_WORD_LO = M_ROW_LO + ROW_W;
	localparam int M_DATA_W  = 40;

	// input modes
	localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TEXT  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_GLYPH = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_LENGTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCROLL_FREEZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCROLL_PERIOD = 2'd2;
	localparam logic [TICK_W-1:0]    PERIOD_RESET      = 8'd30;

	// control from the sequencer to the shift-add unit
	typedef struct packed {
		logic clear;
		logic add;
	} place_ctrl_t;

endpackage

@@ rtl/stscan_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the text store and the font store.
module stscan_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/stscan_place.sv @@
// Shared shifter-adder: places one glyph row at a signed column amount and sums it.
// Depends on stscan_pkg.
module stscan_place (
	input  logic                                clk,
	input  stscan_pkg::place_ctrl_t             ctrl,
	input  logic [stscan_pkg::GLYPH_W-1:0]      glyph,
	input  logic signed [stscan_pkg::AMT_W-1:0] amount,
	output logic [stscan_pkg::WORD_W-1:0]       word
);
	import stscan_pkg::*;

	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] wide_glyph;
	logic [AMT_W-1:0]  neg_amount;
	logic [WORD_W-1:0] placed;

	// left shift for positive amounts, right shift for negative, zero past the word
	always_comb begin
		wide_glyph = WORD_W'(glyph);
		neg_amount = AMT_W'(-amount);
		placed     = '0;
		if (!amount[AMT_W-1]) begin
			if (amount < AMT_W'(WORD_W)) begin
				placed = wide_glyph << amount[4:0];
			end
		end else if (neg_amount < AMT_W'(WORD_W)) begin
			placed = wide_glyph >> neg_amount[4:0];
		end
	end

	// running sum, wraps modulo 2^32
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.add) begin
			acc_q <= acc_q + placed;
		end
	end

	assign word = acc_q;

endmodule

@@ rtl/scrolling_text_row_scanner_unit.sv @@
// Top level of the scrolling text row scanner: sequencer, stores, scroll state.
// Depends on stscan_pkg, stscan_ram and stscan_place.
//
// After reset the block sweeps both stores to zero, one address a cycle over
// all FONT_CODES*8 font addresses (1024 by default), with s_tready low;
// configuration writes are taken during the sweep. A text or glyph write is
// then taken without leaving the idle state. A refresh tick holds s_tready
// low while one text store read per shown character feeds a font store read
// and then the single shared shifter-adder, which sums one character per
// cycle. The finished column word sits in an output register, so the next
// item can be taken while it waits to be read; a tick that finishes while
// that register is still full holds in its last cycle until m_tready frees
// it.
module scrolling_text_row_scanner_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// position [6:0], glyph_row [9:7], value [16:10], zero fill up to bit 23
	input  logic [stscan_pkg::S_DATA_W-1:0]      s_tdata,
	// mode [1:0]
	input  logic [stscan_pkg::MODE_W-1:0]        s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// row_index [2:0], column_word [34:3], zero fill up to bit 39
	output logic [stscan_pkg::M_DATA_W-1:0]      m_tdata,
	input  logic                                 cfg_we,
	input  logic [stscan_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [stscan_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import stscan_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;

	logic [1:0]           state_q;
	logic [FONT_AW-1:0]   clr_q;
	logic [LEN_W-1:0]     text_length_q;
	logic                 scroll_freeze_q;
	logic [TICK_W-1:0]    scroll_period_q;
	logic [ROW_W-1:0]     row_q;
	logic [OFF_W-1:0]     off_q;
	logic [TICK_W-1:0]    tick_q;
	logic [LEN_CNT_W-1:0] cnt_q;
	logic [POS_W-1:0]     pos_q;
	logic                 iss_s1;
	logic [POS_W-1:0]     pos_s1;
	logic                 iss_s2;
	logic                 ok_s2;
	logic [AMT_W-1:0]     amount_s2;
	logic                 m_tvalid_q;
	logic [M_DATA_W-1:0]  m_tdata_q;

	logic [POSN_W-1:0]    in_posn;
	logic [ROW_W-1:0]     in_grow;
	logic [CODE_W-1:0]    in_value;
	logic                 in_acc;
	logic [LEN_CNT_W-1:0] shown_len;
	logic                 issue;
	logic                 done;
	logic                 out_free;
	logic [CODE_W-1:0]    text_rdata;
	logic [GLYPH_W-1:0]   font_rdata;
	logic                 text_we;
	logic [TEXT_AW-1:0]   text_waddr;
	logic [CODE_W-1:0]    text_wdata;
	logic                 font_we;
	logic [FONT_AW-1:0]   font_waddr;
	logic [GLYPH_W-1:0]   font_wdata;
	logic [FONT_AW-1:0]   font_raddr;
	place_ctrl_t          place_ctrl;
	logic [WORD_W-1:0]    word;
	logic [BOUND_W-1:0]   bound;
	logic [TICK_W-1:0]    tick_n;
	logic [OFF_W-1:0]     off_n;

	// input field unpacking
	assign in_posn  = s_tdata[S_POSN_LO +: POSN_W];
	assign in_grow  = s_tdata[S_GROW_LO +: ROW_W];
	assign in_value = s_tdata[S_VALUE_LO +: CODE_W];
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// length clamped to the text store
	always_comb begin
		if ({1'b0, text_length_q} > (LEN_W + 1)'(MAX_TEXT)) begin
			shown_len = LEN_CNT_W'(MAX_TEXT);
		end else begin
			shown_len = LEN_CNT_W'(text_length_q);
		end
	end

	assign issue    = (state_q == ST_RUN) && (cnt_q < shown_len);
	assign done     = (state_q == ST_RUN) && !issue && !iss_s1 && !iss_s2;
	assign out_free = !m_tvalid_q || m_tready;

	// store write ports: clearing sweep or accepted write items
	always_comb begin
		text_we    = 1'b0;
		text_waddr = in_posn[TEXT_AW-1:0];
		text_wdata = in_value;
		font_we    = 1'b0;
		font_waddr = {in_posn[FONT_CODE_W-1:0], in_grow};
		font_wdata = in_value[GLYPH_W-1:0];
		if (state_q == ST_CLEAR) begin
			text_we    = (clr_q < FONT_AW'(MAX_TEXT));
			text_waddr = clr_q[TEXT_AW-1:0];
			text_wdata = '0;
			font_we    = 1'b1;
			font_waddr = clr_q;
			font_wdata = '0;
		end else if (in_acc) begin
			text_we = (s_tuser == MODE_TEXT) &&
				({1'b0, in_posn} < (POSN_W + 1)'(MAX_TEXT));
			font_we = (s_tuser == MODE_GLYPH) &&
				({1'b0, in_posn} < (POSN_W + 1)'(FONT_CODES));
		end
	end

	// glyph lookup for the character read in the previous cycle
	assign font_raddr = {text_rdata[FONT_CODE_W-1:0], row_q};

	stscan_ram #(.WIDTH(CODE_W), .DEPTH(MAX_TEXT)) u_text_ram (
		.clk   (clk),
		.we    (text_we),
		.waddr (text_waddr),
		.wdata (text_wdata),
		.raddr (cnt_q[TEXT_AW-1:0]),
		.rdata (text_rdata)
	);

	stscan_ram #(.WIDTH(GLYPH_W), .DEPTH(FONT_DEPTH)) u_font_ram (
		.clk   (clk),
		.we    (font_we),
		.waddr (font_waddr),
		.wdata (font_wdata),
		.raddr (font_raddr),
		.rdata (font_rdata)
	);

	// shift-add unit control
	assign place_ctrl.clear = in_acc && (s_tuser == MODE_TICK);
	assign place_ctrl.add   = iss_s2 && ok_s2;

	stscan_place u_place (
		.clk    (clk),
		.ctrl   (place_ctrl),
		.glyph  (font_rdata),
		.amount ($signed(amount_s2)),
		.word   (word)
	);

	// scroll state after a tick
	always_comb begin
		bound  = BOUND_W'(shown_len) * BOUND_W'(GLYPH_PITCH) + BOUND_W'(WRAP_EXTRA);
		tick_n = tick_q + 1'b1;
		off_n  = off_q;
		if (!scroll_freeze_q) begin
			if (tick_n == scroll_period_q) begin
				tick_n = '0;
				off_n  = off_q + 1'b1;
			end
			if (CMP_W'(off_n) >= CMP_W'(bound)) begin
				off_n = '0;
			end
		end else begin
			off_n = OFF_W'(FROZEN_OFFSET);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_length_q   <= '0;
			scroll_freeze_q <= 1'b0;
			scroll_period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEXT_LENGTH:   text_length_q   <= cfg_data[LEN_W-1:0];
				REG_SCROLL_FREEZE: scroll_freeze_q <= cfg_data[0];
				REG_SCROLL_PERIOD: scroll_period_q <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, sweep counter and scroll state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			row_q   <= '0;
			off_q   <= '0;
			tick_q  <= '0;
			cnt_q   <= '0;
			pos_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == FONT_AW'(FONT_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					cnt_q <= '0;
					pos_q <= POS_W'(START_POS);
					if (in_acc && (s_tuser == MODE_TICK)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
						pos_q <= pos_q + POS_W'(GLYPH_PITCH);
					end
					if (done && out_free) begin
						row_q   <= row_q + 1'b1;
						tick_q  <= tick_n;
						off_q   <= off_n;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// read pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1 <= 1'b0;
			iss_s2 <= 1'b0;
		end else begin
			iss_s1 <= issue;
			iss_s2 <= iss_s1;
		end
	end

	// read pipeline payload: column position and shift amount
	always_ff @(posedge clk) begin
		pos_s1    <= pos_q;
		ok_s2     <= ({1'b0, text_rdata} < (CODE_W + 1)'(FONT_CODES));
		amount_s2 <= AMT_W'(pos_s1) - AMT_W'(off_q);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (done && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && out_free) begin
			m_tdata_q <= M_DATA_W'({word, row_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for scrolling_text_row_scanner_unit: stream driver, monitor and
// a cycle-free row/column-word predictor. Depends on stscan_pkg and the rtl sources.
module tb_top;
	import stscan_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 80;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int HOLD_AFTER    = 400;
	localparam int HOLD_CYCLES   = 600;
	localparam int CHAR_BASE     = 65;

	typedef struct {
		logic [MODE_W-1:0]  mode;
		logic [POSN_W-1:0]  posn;
		logic [ROW_W-1:0]   grow;
		logic [CODE_W-1:0]  value;
	} scan_item_t;

	typedef struct {
		logic [ROW_W-1:0]   row;
		logic [WORD_W-1:0]  word;
	} row_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [MODE_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor state
	logic [CODE_W-1:0]  text_mem [MAX_TEXT];
	logic [GLYPH_W-1:0] font_mem [FONT_DEPTH];
	logic [ROW_W-1:0]   row_q = '0;
	logic [OFF_W-1:0]   offset_q = '0;
	logic [TICK_W-1:0]  ticks_q = '0;
	logic [LEN_W-1:0]   len_reg = '0;
	logic               freeze_reg = 1'b0;
	logic [TICK_W-1:0]  period_reg = PERIOD_RESET;

	scan_item_t pending_items[$];
	row_word_t  column_words_due[$];

	scan_item_t cur_item;
	logic [S_DATA_W-1:0] drv_data;
	int  send_gap = 0;
	int  recv_stall = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	bit  idle_en = 1'b0;
	int  n_accepted = 0;
	int  n_mismatch = 0;
	int  n_cycles = 0;
	logic [ROW_W-1:0]  got_row;
	logic [WORD_W-1:0] got_word;
	row_word_t due;

	scrolling_text_row_scanner_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// store writes, and for a refresh tick the expected row and column word
	task automatic advance_scanner(input scan_item_t it);
		int len;
		int amt;
		int bound;
		logic [CODE_W-1:0] code;
		logic [WORD_W-1:0] glyph;
		logic [WORD_W-1:0] word;
		row_word_t rw;
		case (it.mode)
			MODE_TEXT: begin
				if (it.posn < MAX_TEXT)
					text_mem[it.posn[TEXT_AW-1:0]] = it.value;
			end
			MODE_GLYPH: begin
				if (it.posn < FONT_CODES)
					font_mem[{it.posn[FONT_CODE_W-1:0], it.grow}] = it.value[GLYPH_W-1:0];
			end
			MODE_TICK: begin
				len = (len_reg > MAX_TEXT) ? MAX_TEXT : int'(len_reg);
				word = '0;
				for (int i = 0; i < len; i++) begin
					code = text_mem[i];
					glyph = '0;
					if (code < FONT_CODES)
						glyph = {27'd0, font_mem[{code[FONT_CODE_W-1:0], row_q}]};
					amt = (i + 6) * GLYPH_PITCH - int'(offset_q);
					if (amt >= 32 || amt <= -32)
						glyph = '0;
					else if (amt >= 0)
						glyph = glyph << amt;
					else
						glyph = glyph >> (-amt);
					word = word + glyph;
				end
				rw.row = row_q;
				rw.word = word;
				column_words_due.push_back(rw);
				row_q = row_q + 1'b1;
				ticks_q = ticks_q + 1'b1;
				if (!freeze_reg) begin
					if (ticks_q == period_reg) begin
						ticks_q = '0;
						offset_q = offset_q + 1'b1;
					end
					bound = len * GLYPH_PITCH + WRAP_EXTRA;
					if (int'(offset_q) >= bound)
						offset_q = '0;
				end else begin
					offset_q = OFF_W'(FROZEN_OFFSET);
				end
			end
			default: ;
		endcase
	endtask

	// driver: presents queued items, with random idle bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				advance_scanner(cur_item);
				n_accepted <= n_accepted + 1;
			end
			if (s_tvalid && !s_tready) begin
				// hold the offered transaction
			end else if (send_gap != 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				send_gap = $urandom_range(0, 8);
				s_tvalid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				cur_item = pending_items.pop_front();
				drv_data = '0;
				drv_data[S_POSN_LO +: POSN_W] = cur_item.posn;
				drv_data[S_GROW_LO +: ROW_W] = cur_item.grow;
				drv_data[S_VALUE_LO +: CODE_W] = cur_item.value;
				s_tdata <= drv_data;
				s_tuser <= cur_item.mode;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// one long receiver hold-off so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && n_accepted >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor: compare each result transaction with the oldest due column word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_row = m_tdata[M_ROW_LO +: ROW_W];
				got_word = m_tdata[M_WORD_LO +: WORD_W];
				if (column_words_due.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("unexpected result: row %0d word %08h", got_row, got_word);
				end else begin
					due = column_words_due.pop_front();
					if (got_row !== due.row || got_word !== due.word) begin
						n_mismatch++;
						if (n_mismatch <= 10)
							$display("mismatch: row exp %0d got %0d, word exp %08h got %08h",
								due.row, got_row, due.word, got_word);
					end
				end
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (recv_stall != 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				recv_stall = $urandom_range(0, 8);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("scrolling_text_row_scanner_unit verification failed");
			$finish;
		end
	end

	task automatic push_item(input logic [MODE_W-1:0] mode, input int posn, input int grow,
			input int value);
		scan_item_t it;
		it.mode = mode;
		it.posn = posn[POSN_W-1:0];
		it.grow = grow[ROW_W-1:0];
		it.value = value[CODE_W-1:0];
		pending_items.push_back(it);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[CFG_DATA_W-1:0];
		case (idx)
			REG_TEXT_LENGTH:   len_reg = data[LEN_W-1:0];
			REG_SCROLL_FREEZE: freeze_reg = data[0];
			REG_SCROLL_PERIOD: period_reg = data[TICK_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every item is taken and every column word has come out
	task automatic settle();
		@(negedge clk);
		while (pending_items.size() != 0 || s_tvalid || column_words_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ticks, glyph and text writes over a mostly small character set, with some noise
	task automatic run_phase(input int len, input int freeze, input int period, input int n,
			input int tick_pct, input bit idle);
		int r;
		settle();
		set_reg(REG_TEXT_LENGTH, len);
		set_reg(REG_SCROLL_FREEZE, freeze);
		set_reg(REG_SCROLL_PERIOD, period);
		@(negedge clk);
		idle_en = idle;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				push_item(MODE_UNUSED, $urandom_range(0, 127), $urandom_range(0, 7),
					$urandom_range(0, 127));
			else if (r < 3 + tick_pct)
				push_item(MODE_TICK, $urandom_range(0, 127), $urandom_range(0, 7),
					$urandom_range(0, 127));
			else if (r < 3 + tick_pct + (97 - tick_pct) / 2)
				push_item(MODE_GLYPH,
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
						: CHAR_BASE + $urandom_range(0, 15),
					$urandom_range(0, 7), $urandom_range(0, 127));
			else
				push_item(MODE_TEXT,
					($urandom_range(0, 7) == 0) ? $urandom_range(64, 127) : $urandom_range(0, 63),
					$urandom_range(0, 7),
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
						: CHAR_BASE + $urandom_range(0, 15));
		end
	endtask

	initial begin
		for (int i = 0; i < MAX_TEXT; i++)
			text_mem[i] = '0;
		for (int i = 0; i < FONT_DEPTH; i++)
			font_mem[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: store extremes, ignored writes, unused mode, then ticks
		set_reg(REG_TEXT_LENGTH, 4);
		set_reg(REG_SCROLL_FREEZE, 0);
		set_reg(REG_SCROLL_PERIOD, 1);
		@(negedge clk);
		idle_en = 1'b1;
		push_item(MODE_GLYPH, 0, 0, 127);
		push_item(MODE_GLYPH, 127, 7, 31);
		push_item(MODE_GLYPH, CHAR_BASE, 1, 85);
		push_item(MODE_TEXT, 0, 0, 0);
		push_item(MODE_TEXT, 63, 7, 127);
		push_item(MODE_TEXT, 1, 0, CHAR_BASE);
		push_item(MODE_TEXT, 2, 0, 127);
		push_item(MODE_TEXT, 3, 0, CHAR_BASE);
		push_item(MODE_TEXT, 64, 0, CHAR_BASE);
		push_item(MODE_TEXT, 127, 7, 0);
		push_item(MODE_UNUSED, 127, 7, 127);
		for (int k = 0; k < 14; k++)
			push_item(MODE_TICK, 0, 0, 0);

		// random phases over a spread of register settings
		run_phase(64, 0, 1, 260, 30, 1'b1);
		run_phase(0, 0, 30, 150, 60, 1'b1);
		run_phase(127, 0, 2, 250, 60, 1'b1);
		run_phase(12, 1, 5, 200, 60, 1'b1);
		run_phase(7, 0, 0, 260, 70, 1'b0);
		run_phase(33, 0, 3, 250, 60, 1'b1);
		run_phase(64, 0, 255, 250, 60, 1'b1);
		run_phase(5, 0, 1, 300, 60, 1'b0);

		settle();
		if (n_mismatch == 0 && column_words_due.size() == 0)
			$display("scrolling_text_row_scanner_unit verification clean");
		else
			$display("scrolling_text_row_scanner_unit verification failed");
		$finish;
	end

endmodule
